@@ sv/fmpc_pkg.sv @@
`default_nettype none

package fmpc_pkg;

  // Default width of the millisecond time base
  localparam int unsigned TIME_BITS_DEF = 32;

  // Debounce and count qualification windows, in ms
  localparam int unsigned DEBOUNCE_MS  = 50;
  localparam int unsigned COUNT_MS     = 500;
  localparam int unsigned MS_PER_MIN   = 60000;
  localparam int unsigned NO_MIN_LIMIT = 10000000;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOL_PER_TICK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FLOW     = 1'd1;

  localparam logic [15:0] VOL_PER_TICK_RST = 16'd1000;
  localparam logic [15:0] MIN_FLOW_RST     = 16'd100;

  // Input item codes
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_IMPULSE = 1'b1;

  typedef struct packed {
    logic cmd;
    logic pin_level;
  } fmpc_in_t;

  typedef struct packed {
    logic [47:0] total_volume;
    logic [31:0] flow_rate;
    logic        volume_updated;
    logic        flow_updated;
  } fmpc_out_t;

endpackage

`default_nettype wire

@@ sv/flow_meter_pulse_counter.sv @@
`default_nettype none

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------
// in       | input     | in_valid_i / in_ready_o    | in_data_i  (fmpc_in_t)
// out      | output    | out_valid_o / out_ready_i  | out_data_o (fmpc_out_t)
// cfg      | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// An impulse goes from transfer to S_DONE. A tick passes S_EVAL, then S_DIV when
// a counted pulse recomputes the flow, then S_LMUL, S_LCMP and S_DONE. S_DIV is
// the one-bit-per-cycle restoring divider. in_ready_o is high only
// while the sequencer is idle. The result register frees the sequencer: a new
// item is taken while the previous result waits for out_ready_i, and the
// sequencer holds in its final state only if that register is still full.
// Reset clears all meter state and loads the register defaults; there is no
// clearing pass.

module flow_meter_pulse_counter #(
  parameter int unsigned TIME_BITS = fmpc_pkg::TIME_BITS_DEF
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  wire  fmpc_pkg::fmpc_in_t               in_data_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output fmpc_pkg::fmpc_out_t                    out_data_o,
  input  wire                                    cfg_we_i,
  input  wire  [fmpc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire  [fmpc_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  import fmpc_pkg::*;

  // Wide enough to hold the time base and any 32-bit value
  localparam int unsigned WB = (TIME_BITS > 32) ? TIME_BITS : 32;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;  // qualify the pending impulse
  localparam logic [2:0] S_DIV  = 3'd2;  // flow = product / interval
  localparam logic [2:0] S_LMUL = 3'd3;  // zero flow limit, multiply
  localparam logic [2:0] S_LCMP = 3'd4;  // zero flow limit, compare
  localparam logic [2:0] S_DONE = 3'd5;  // load the result register

  logic [2:0]           state_q, state_d;

  // Configuration
  logic [15:0]          vpt_q, min_flow_q;

  // Meter state
  logic [TIME_BITS-1:0] now_q, imp_time_q, last_cnt_q;
  logic                 pending_q, count_seen_q;
  logic [47:0]          total_q;
  logic [31:0]          flow_q;

  // Per-item status
  logic                 pin_q, vol_upd_q, flow_upd_q;

  // Restoring divider for the flow
  logic [TIME_BITS-1:0] dvs_q, rem_q;
  logic [31:0]          num_q;
  logic [4:0]           div_cnt_q;

  // Zero flow limit product
  logic [48:0]          lim_prod_q;

  // Result register
  logic                 out_valid_q;
  fmpc_out_t            out_data_q;

  logic [31:0]          prod;
  logic [TIME_BITS-1:0] span, dt;
  logic [WB-1:0]        span_w;
  logic [31:0]          span32;
  logic [48:0]          vol_sum;
  logic [TIME_BITS:0]   rem_sh;
  logic                 div_ge;
  logic                 lim_hit;
  logic                 load_out;
  logic                 in_fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign load_out    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Pulse volume times ms per minute; always below 2^32
  assign prod = 32'(vpt_q) * 32'(MS_PER_MIN);

  // Elapsed times wrap with the time base
  assign span = now_q - imp_time_q;
  assign dt   = now_q - last_cnt_q;

  // Clamp elapsed time to 32 bits; every limit is below 2^32 - 1
  assign span_w = WB'(span);
  assign span32 = (span_w > WB'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : span_w[31:0];

  assign vol_sum = {1'b0, total_q} + 49'(vpt_q);

  // One restoring step: shift in the next numerator bit, subtract if it fits
  assign rem_sh = {rem_q, num_q[31]};
  assign div_ge = (rem_sh >= {1'b0, dvs_q});

  // Elapsed >= floor(P / m) is the same as P < (elapsed + 1) * m
  always_comb begin
    if (min_flow_q == 16'd0) begin
      lim_hit = (span32 >= 32'(NO_MIN_LIMIT));
    end else begin
      lim_hit = (49'(prod) < lim_prod_q);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (in_data_i.cmd == CMD_IMPULSE) ? S_DONE : S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_LMUL;
        if (pending_q && (span >= TIME_BITS'(DEBOUNCE_MS)) && pin_q &&
            (span >= TIME_BITS'(COUNT_MS)) && count_seen_q &&
            (dt != '0)) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt_q == 5'd0) begin
          state_d = S_LMUL;
        end
      end
      S_LMUL: state_d = S_LCMP;
      S_LCMP: state_d = S_DONE;
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      vpt_q        <= VOL_PER_TICK_RST;
      min_flow_q   <= MIN_FLOW_RST;
      now_q        <= '0;
      imp_time_q   <= '0;
      last_cnt_q   <= '0;
      pending_q    <= 1'b0;
      count_seen_q <= 1'b0;
      total_q      <= '0;
      flow_q       <= '0;
      vol_upd_q    <= 1'b0;
      flow_upd_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_VOL_PER_TICK: vpt_q      <= cfg_data_i;
          REG_MIN_FLOW:     min_flow_q <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            vol_upd_q  <= 1'b0;
            flow_upd_q <= 1'b0;
            if (in_data_i.cmd == CMD_IMPULSE) begin
              // Latch the time; a new impulse re-latches it
              imp_time_q <= now_q;
              pending_q  <= 1'b1;
            end else begin
              now_q <= now_q + TIME_BITS'(1);
            end
          end
        end
        S_EVAL: begin
          if (pending_q && (span >= TIME_BITS'(DEBOUNCE_MS)) && pin_q) begin
            pending_q <= 1'b0;
            if (span >= TIME_BITS'(COUNT_MS)) begin
              // Count the pulse, saturate the total
              total_q    <= vol_sum[48] ? '1 : vol_sum[47:0];
              vol_upd_q  <= 1'b1;
              last_cnt_q <= now_q;
              if (!count_seen_q) begin
                count_seen_q <= 1'b1;
              end else if (dt == '0) begin
                flow_q     <= '1;
                flow_upd_q <= 1'b1;
              end
            end
          end
        end
        S_DIV: begin
          if (div_cnt_q == 5'd0) begin
            flow_q     <= {num_q[30:0], div_ge};
            flow_upd_q <= 1'b1;
          end
        end
        S_LCMP: begin
          // Drop the flow once the impulse gap reaches the limit
          if ((flow_q != '0) && lim_hit) begin
            flow_q     <= '0;
            flow_upd_q <= 1'b1;
          end
        end
        default: ;
      endcase

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pin_q <= in_data_i.pin_level;
    end

    case (state_q)
      S_EVAL: begin
        num_q     <= prod;
        dvs_q     <= dt;
        rem_q     <= '0;
        div_cnt_q <= 5'd31;
      end
      S_DIV: begin
        num_q     <= {num_q[30:0], div_ge};
        rem_q     <= div_ge ? TIME_BITS'(rem_sh - {1'b0, dvs_q}) : rem_sh[TIME_BITS-1:0];
        div_cnt_q <= div_cnt_q - 5'd1;
      end
      S_LMUL: begin
        lim_prod_q <= 49'({1'b0, span32} + 33'd1) * 49'(min_flow_q);
      end
      default: ;
    endcase

    if (load_out) begin
      out_data_q.total_volume   <= total_q;
      out_data_q.flow_rate      <= flow_q;
      out_data_q.volume_updated <= vol_upd_q;
      out_data_q.flow_updated   <= flow_upd_q;
    end
  end

endmodule

`default_nettype wire

@@ tb/fmpc_checker.sv @@
`timescale 1ns / 100ps

module fmpc_checker
  import fmpc_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  in_ready_i,
  input  fmpc_in_t             in_data_i,
  input  wire                  out_valid_i,
  input  wire                  out_ready_i,
  input  fmpc_out_t            out_data_i,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned          fail_cnt_o,
  output int unsigned          open_cnt_o
);

  localparam logic [47:0] TOTAL_MAX = '1;
  localparam logic [63:0] RATE_MAX  = 64'hFFFF_FFFF;

  // Shadow copy of the meter
  logic [15:0]          vpt_cfg;
  logic [15:0]          floor_cfg;
  logic [TIME_BITS-1:0] ms_clock;
  logic [TIME_BITS-1:0] stamp_ms;
  logic [TIME_BITS-1:0] last_pulse_ms;
  logic                 armed;
  logic                 primed;
  logic [47:0]          vol_acc;
  logic [31:0]          flow_acc;

  fmpc_out_t   readings_q[$];
  fmpc_out_t   want;
  int unsigned fail_n;

  // Advance the shadow meter by one item and return the reading it should give.
  function automatic fmpc_out_t meter_step(fmpc_in_t item);
    fmpc_out_t            res;
    logic [TIME_BITS-1:0] since;
    logic [63:0]          quot;
    logic [63:0]          cutoff;
    res = '0;
    if (item.cmd == CMD_IMPULSE) begin
      stamp_ms = ms_clock;
      armed    = 1'b1;
    end else begin
      ms_clock = ms_clock + TIME_BITS'(1);
      since    = ms_clock - stamp_ms;
      if (armed && since >= DEBOUNCE_MS && item.pin_level) begin
        if (since >= COUNT_MS) begin
          vol_acc = (48'(vpt_cfg) > TOTAL_MAX - vol_acc) ? TOTAL_MAX : vol_acc + 48'(vpt_cfg);
          res.volume_updated = 1'b1;
          // the very first pulse only starts the interval
          if (primed) begin
            since    = ms_clock - last_pulse_ms;
            quot     = (since == '0) ? RATE_MAX : 64'(vpt_cfg) * MS_PER_MIN / 64'(since);
            flow_acc = (quot > RATE_MAX) ? RATE_MAX[31:0] : quot[31:0];
            res.flow_updated = 1'b1;
          end
          primed        = 1'b1;
          last_pulse_ms = ms_clock;
        end
        armed = 1'b0;
      end
      cutoff = (floor_cfg == '0) ? 64'(NO_MIN_LIMIT)
                                 : 64'(vpt_cfg) * MS_PER_MIN / 64'(floor_cfg);
      since  = ms_clock - stamp_ms;
      if (flow_acc != '0 && 64'(since) >= cutoff) begin
        flow_acc = '0;
        res.flow_updated = 1'b1;
      end
    end
    res.total_volume = vol_acc;
    res.flow_rate    = flow_acc;
    return res;
  endfunction

  function automatic void check_field(string label, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want_v, got_v);
      fail_n++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpt_cfg       = VOL_PER_TICK_RST;
      floor_cfg     = MIN_FLOW_RST;
      ms_clock      = '0;
      stamp_ms      = '0;
      last_pulse_ms = '0;
      armed         = 1'b0;
      primed        = 1'b0;
      vol_acc       = '0;
      flow_acc      = '0;
      fail_n        = 0;
      readings_q.delete();
      fail_cnt_o <= 0;
      open_cnt_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (readings_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data_i);
          fail_n++;
        end else begin
          want = readings_q.pop_front();
          check_field("total_volume", want.total_volume, out_data_i.total_volume);
          check_field("flow_rate", want.flow_rate, out_data_i.flow_rate);
          check_field("volume_updated", want.volume_updated, out_data_i.volume_updated);
          check_field("flow_updated", want.flow_updated, out_data_i.flow_updated);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_VOL_PER_TICK: vpt_cfg   = cfg_data_i;
          REG_MIN_FLOW:     floor_cfg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) readings_q.push_back(meter_step(in_data_i));
      fail_cnt_o <= fail_n;
      open_cnt_o <= readings_q.size();
    end
  end

endmodule

@@ tb/flow_meter_pulse_counter_test.sv @@
`timescale 1ns / 100ps

module flow_meter_pulse_counter_test;
  import fmpc_pkg::*;

  // Hang guard, far above the slowest legal run
  localparam int unsigned CYCLE_LIMIT   = 20_000_000;
  // Long receiver hold-off: fills the result register and stalls the input side
  localparam int unsigned CHOKE_CYCLES  = 400;
  // Wait after the last result, longer than the slowest item
  localparam int unsigned SETTLE_CYCLES = 60;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  fmpc_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  fmpc_out_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned fail_n;
  int unsigned open_n;
  int unsigned sent_n;
  int unsigned cycle_n;
  // steady: no gaps on either side; choke_*: one long receiver hold-off
  bit          steady;
  bit          choke_req;
  bit          choke_done;

  always #5 clk = ~clk;

  always @(posedge clk) cycle_n <= cycle_n + 1;

  flow_meter_pulse_counter u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  fmpc_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_cnt_o  (fail_n),
    .open_cnt_o  (open_n)
  );

  // Gap length in cycles: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offer one item and hold it until the transfer. Valid stays high on return,
  // so back-to-back items never drop it.
  task automatic send_item(input logic kind, input logic level);
    int unsigned idle;
    idle = pick_gap();
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{cmd: kind, pin_level: level};
    // ready is sampled as it stood before this edge
    do @(posedge clk); while (!in_ready);
    sent_n++;
  endtask

  // Drop valid and wait until every reading has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_n != 0);
  endtask

  // Write both registers with the meter idle.
  task automatic retune(input logic [15:0] vol, input logic [15:0] minf);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_VOL_PER_TICK;
    cfg_data <= vol;
    @(posedge clk);
    cfg_idx  <= REG_MIN_FLOW;
    cfg_data <= minf;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // One switch closure: an impulse, a bouncing line for the debounce window,
  // then the line held low until the tick that is goal ms after the impulse,
  // where it goes high. goal >= COUNT_MS gives a counted pulse, anything
  // shorter only clears the pending impulse. A single re-latch may land
  // inside the bounce window and restarts the timing.
  task automatic qualify_pulse(input int unsigned goal);
    int unsigned k;
    bit          relatched;
    send_item(CMD_IMPULSE, 1'($urandom_range(0, 1)));
    k         = 0;
    relatched = 1'b0;
    while (k < goal) begin
      if (k + 1 < DEBOUNCE_MS) begin
        if (!relatched && $urandom_range(0, 39) == 0) begin
          send_item(CMD_IMPULSE, 1'($urandom_range(0, 1)));
          relatched = 1'b1;
          k         = 0;
        end else begin
          k++;
          send_item(CMD_TICK, 1'($urandom_range(0, 1)));
        end
      end else begin
        k++;
        send_item(CMD_TICK, k == goal);
      end
    end
  endtask

  // Mix of switch closures, near misses, line noise and quiet stretches.
  // The owed pulses come first, then the cheaper mix fills up the item count.
  task automatic run_phase(input int unsigned min_items, input int unsigned min_pulses);
    int unsigned start;
    int unsigned pulses;
    int unsigned pick;
    int unsigned n;
    start  = sent_n;
    pulses = 0;
    while (sent_n - start < min_items || pulses < min_pulses) begin
      steady = ($urandom_range(0, 4) == 0);
      pick   = (pulses < min_pulses) ? 0 : $urandom_range(45, 99);
      if (pick < 45) begin
        // counted pulse: mostly just past the count window, exactly on it,
        // or late enough for the zero-flow cutoff to bite
        n = $urandom_range(0, 9);
        qualify_pulse(n == 0 ? COUNT_MS :
                      n < 8  ? $urandom_range(COUNT_MS, COUNT_MS + 40) :
                               $urandom_range(COUNT_MS + 41, 1100));
        pulses++;
      end else if (pick < 60) begin
        // debounced but too short to count, edges of the window included
        n = $urandom_range(0, 2);
        qualify_pulse(n == 0 ? DEBOUNCE_MS :
                      n == 1 ? COUNT_MS - 1 :
                               $urandom_range(DEBOUNCE_MS, COUNT_MS - 1));
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 40))
          send_item($urandom_range(0, 9) < 3 ? CMD_IMPULSE : CMD_TICK,
                    1'($urandom_range(0, 1)));
      end else begin
        // quiet line: lets the flow decay to zero
        repeat ($urandom_range(50, 300)) send_item(CMD_TICK, 1'($urandom_range(0, 1)));
      end
    end
    steady = 1'b0;
  endtask

  // Receiver: random ready pattern, plus the one long hold-off on request.
  initial begin
    int unsigned idle;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      idle = pick_gap();
      if (choke_req && !choke_done) begin
        idle       = CHOKE_CYCLES;
        choke_done = 1'b1;
      end
      if (idle != 0) begin
        out_ready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    wait (cycle_n == CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [15:0] vol_pick;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening on reset settings: both item kinds with both line
    // levels, an impulse re-latched while pending, back-to-back transfers
    steady = 1'b1;
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_IMPULSE, 1'b1);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_IMPULSE, 1'b0);
    send_item(CMD_IMPULSE, 1'b1);
    steady = 1'b0;
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_IMPULSE, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b1);

    // Reset settings; the first pulse only starts the interval. The long
    // receiver hold-off happens here while the sender keeps offering.
    choke_req = 1'b1;
    run_phase(60, 1);

    // Smallest volume against the largest floor: a cutoff of zero
    retune(16'd1, 16'hFFFF);
    run_phase(60, 0);

    // Largest volume, floor disabled: the next pulse sets a large flow
    retune(16'hFFFF, 16'd0);
    run_phase(60, 1);

    // Zero volume: nothing accumulates and the cutoff of zero drops the flow
    retune(16'd0, 16'd1);
    run_phase(60, 0);

    // Cutoff of 600 ms, inside the reach of the long closures
    retune(16'd12, 16'd1200);
    run_phase(60, 0);

    // Largest volume over the smallest floor
    retune(16'hFFFF, 16'd1);
    run_phase(60, 0);

    // Random pair with a cutoff no longer than 3 s
    vol_pick = 16'($urandom_range(1, 3000));
    retune(vol_pick, 16'($urandom_range(vol_pick * 20, 16'hFFFF)));
    run_phase(60, 0);

    // Anything goes
    retune(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
    run_phase(60, 0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_n == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/fmpc_pkg.sv
sv/flow_meter_pulse_counter.sv
tb/fmpc_checker.sv
tb/flow_meter_pulse_counter_test.sv
